// File: sv/hkc_pkg.sv
// Shared types and codes of the keyed set-associative cache directory.
// Used by hkc_way_update and hash_keyed_set_assoc_cache; depends on nothing.
package hkc_pkg;

   // Request opcodes
   localparam logic OP_LOOKUP = 1'b0;
   localparam logic OP_INSERT = 1'b1;

   // Lookup status codes
   localparam logic [1:0] STATUS_MISS    = 2'd0;
   localparam logic [1:0] STATUS_ABSENT  = 2'd1;
   localparam logic [1:0] STATUS_PRESENT = 2'd2;

   // Length that marks a key known to be absent
   localparam logic signed [31:0] LEN_ABSENT = -32'sd1;

   // One directory entry, as kept in one way of a set row
   typedef struct packed {
      logic [63:0]        tag0;
      logic [63:0]        tag1;
      logic [63:0]        tag2;
      logic [63:0]        tag3;
      logic signed [31:0] length;
      logic [31:0]        handle;
   } entry_type;

   localparam int ENTRY_BITS = $bits(entry_type);

   // Captured input item
   typedef struct packed {
      logic               op;
      logic [63:0]        key_word0;
      logic [63:0]        key_word1;
      logic [63:0]        key_word2;
      logic [63:0]        key_word3;
      logic signed [31:0] data_length;
      logic [31:0]        payload_handle;
   } req_item_type;

   // Result item
   typedef struct packed {
      logic [1:0]         lookup_status;
      logic signed [31:0] found_length;
      logic [31:0]        found_handle;
      logic               evict_valid;
      logic [31:0]        evict_handle;
   } rsp_item_type;

endpackage

// File: sv/hkc_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module hkc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port, read every cycle
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/hkc_way_update.sv
// Tag compare, result build and move-to-front reorder of one set row.
// Depends on hkc_pkg.
module hkc_way_update #(
   parameter int WAYS = 4
) (
   input  hkc_pkg::req_item_type            req,
   input  hkc_pkg::entry_type [WAYS-1:0]    old_row,
   output hkc_pkg::entry_type [WAYS-1:0]    new_row,
   output logic                             row_we,
   output hkc_pkg::rsp_item_type            rsp
);
   import hkc_pkg::*;

   logic [WAYS-1:0]       match;
   logic [WAYS-1:0]       first_hit;
   logic [WAYS-1:0]       shift_sel;
   logic                  seen;
   logic                  any_hit;
   logic [ENTRY_BITS-1:0] hit_bits;
   entry_type             hit_entry;
   entry_type             fresh;
   logic signed [31:0]    clamped_len;

   // Compare every way against the key
   always_comb begin
      for (int w = 0; w < WAYS; w++) begin
         match[w] = (old_row[w].tag0 == req.key_word0) &&
                    (old_row[w].tag1 == req.key_word1) &&
                    (old_row[w].tag2 == req.key_word2) &&
                    (old_row[w].tag3 == req.key_word3);
      end
   end

   assign any_hit = |match;

   // Keep only the lowest matching way
   always_comb begin
      seen = 1'b0;
      for (int w = 0; w < WAYS; w++) begin
         first_hit[w] = match[w] & ~seen;
         seen         = seen | match[w];
      end
   end

   // Mark ways at or below the hit way (those that shift down on a promote)
   always_comb begin
      shift_sel[WAYS-1] = first_hit[WAYS-1];
      for (int w = WAYS - 2; w >= 0; w--) begin
         shift_sel[w] = shift_sel[w+1] | first_hit[w];
      end
   end

   // Select the hit entry
   always_comb begin
      hit_bits = '0;
      for (int w = 0; w < WAYS; w++) begin
         hit_bits = hit_bits | (first_hit[w] ? ENTRY_BITS'(old_row[w]) : '0);
      end
   end

   assign hit_entry = entry_type'(hit_bits);

   // Build the entry for a new key: clamp length, drop handle of empty payload
   assign clamped_len = (req.data_length < LEN_ABSENT) ? LEN_ABSENT : req.data_length;

   always_comb begin
      fresh.tag0   = req.key_word0;
      fresh.tag1   = req.key_word1;
      fresh.tag2   = req.key_word2;
      fresh.tag3   = req.key_word3;
      fresh.length = clamped_len;
      fresh.handle = (clamped_len > 32'sd0) ? req.payload_handle : 32'd0;
   end

   // Reorder: promote the hit entry, or shift all ways and insert at front
   always_comb begin
      new_row[0] = any_hit ? hit_entry : fresh;
      for (int w = 1; w < WAYS; w++) begin
         new_row[w] = (!any_hit || shift_sel[w]) ? old_row[w-1] : old_row[w];
      end
   end

   assign row_we = (req.op == OP_INSERT);

   // Build the result item
   always_comb begin
      rsp = '0;
      if (req.op == OP_LOOKUP) begin
         if (any_hit) begin
            rsp.lookup_status = (hit_entry.length == LEN_ABSENT) ? STATUS_ABSENT
                                                                 : STATUS_PRESENT;
            rsp.found_length  = hit_entry.length;
            rsp.found_handle  = hit_entry.handle;
         end
      end else if (!any_hit && (old_row[WAYS-1].length > 32'sd0)) begin
         rsp.evict_valid  = 1'b1;
         rsp.evict_handle = old_row[WAYS-1].handle;
      end
   end

endmodule

// File: sv/hash_keyed_set_assoc_cache.sv
// Keyed set-associative cache directory with move-to-front replacement.
// An accepted item waits while its set row is read; the row is then updated, written
// back on an insert, and the result item registered once the output register is free.
// The next item is taken only after that, as the single-port-pair set RAM does a read-modify-write of one set row.
// Reset: a clearing pass writes all 2**SET_BITS set rows to zero, one row per cycle,
// while no request item is taken.
module hash_keyed_set_assoc_cache #(
   parameter int SET_BITS = 12,
   parameter int WAYS     = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_req_type,
   input  logic [63:0]        req_key_word0,
   input  logic [63:0]        req_key_word1,
   input  logic [63:0]        req_key_word2,
   input  logic [63:0]        req_key_word3,
   input  logic signed [31:0] req_data_length,
   input  logic [31:0]        req_payload_handle,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_lookup_status,
   output logic signed [31:0] rsp_found_length,
   output logic [31:0]        rsp_found_handle,
   output logic               rsp_evict_valid,
   output logic [31:0]        rsp_evict_handle
);
   import hkc_pkg::*;

   localparam int NSETS    = 1 << SET_BITS;
   localparam int ROW_BITS = WAYS * ENTRY_BITS;

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_BUSY  = 2'd2;

   logic [1:0]            state_ff, state_in;
   logic [SET_BITS-1:0]   clear_ff, clear_in;
   req_item_type          req_ff, req_in;
   rsp_item_type          rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic                  accept;
   logic                  out_free;
   logic                  finish;
   logic [SET_BITS-1:0]   rd_addr;
   logic [SET_BITS-1:0]   wr_addr;
   logic [ROW_BITS-1:0]   wr_data;
   logic                  wr_en;
   logic [ROW_BITS-1:0]   rd_row;
   entry_type [WAYS-1:0]  old_row;
   entry_type [WAYS-1:0]  new_row;
   logic                  row_we;
   rsp_item_type          upd_rsp;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign finish    = (state_ff == ST_BUSY) && out_free;

   // Set row storage
   hkc_ram #(
      .WIDTH (ROW_BITS),
      .DEPTH (NSETS)
   ) u_set_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_row)
   );

   assign old_row = rd_row;

   // Compare and reorder the set row
   hkc_way_update #(
      .WAYS (WAYS)
   ) u_way_update (
      .req     (req_ff),
      .old_row (old_row),
      .new_row (new_row),
      .row_we  (row_we),
      .rsp     (upd_rsp)
   );

   // Read the set of the incoming item; hold the set while the item waits
   assign rd_addr = (state_ff == ST_IDLE) ? req_key_word0[SET_BITS-1:0]
                                          : req_ff.key_word0[SET_BITS-1:0];

   // Write back the updated row, or zero a row during the clearing pass
   always_comb begin
      if (state_ff == ST_CLEAR) begin
         wr_en   = 1'b1;
         wr_addr = clear_ff;
         wr_data = '0;
      end else begin
         wr_en   = finish && row_we;
         wr_addr = req_ff.key_word0[SET_BITS-1:0];
         wr_data = new_row;
      end
   end

   // Sequence clearing, idle and update
   always_comb begin
      state_in = state_ff;
      clear_in = clear_ff;
      case (state_ff)
         ST_CLEAR: begin
            clear_in = clear_ff + 1'b1;
            if (&clear_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_BUSY;
            end
         end
         ST_BUSY: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
            clear_in = '0;
         end
      endcase
   end

   // Capture the item
   always_comb begin
      req_in = req_ff;
      if (accept) begin
         req_in.op             = req_req_type;
         req_in.key_word0      = req_key_word0;
         req_in.key_word1      = req_key_word1;
         req_in.key_word2      = req_key_word2;
         req_in.key_word3      = req_key_word3;
         req_in.data_length    = req_data_length;
         req_in.payload_handle = req_payload_handle;
      end
   end

   // Load the output register, drop the item once taken
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (finish) begin
         rsp_in       = upd_rsp;
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clear_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clear_ff     <= clear_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_lookup_status = rsp_ff.lookup_status;
   assign rsp_found_length  = rsp_ff.found_length;
   assign rsp_found_handle  = rsp_ff.found_handle;
   assign rsp_evict_valid   = rsp_ff.evict_valid;
   assign rsp_evict_handle  = rsp_ff.evict_handle;

endmodule
